### hdl/ccpg_pkg.sv
package ccpg_pkg;

  localparam int unsigned SCREEN_W = 240;
  localparam int unsigned SCREEN_H = 320;
  localparam int unsigned NUM_PTS  = 8;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // on start only the four axis slots carry distinct points
  localparam logic [NUM_PTS-1:0] START_SLOTS = 8'b0011_0101;

  typedef struct packed {
    logic [NUM_PTS-1:0][9:0] px;
    logic [NUM_PTS-1:0][9:0] py;
    logic [NUM_PTS-1:0]      mask;
    logic [15:0]             color;
    logic                    finished;
  } batch_t;

  function automatic logic on_screen(logic [11:0] x, logic [11:0] y);
    on_screen = !x[11] && !y[11] && (32'(x[10:0]) < SCREEN_W) && (32'(y[10:0]) < SCREEN_H);
  endfunction

endpackage

### hdl/ccpg_step.sv
module ccpg_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ccpg_pkg::cmd_e      cmd_i,
  input  logic [10:0]         center_x_i,
  input  logic [10:0]         center_y_i,
  input  logic [9:0]          radius_i,
  input  logic [15:0]         pen_color_i,
  output ccpg_pkg::batch_t    batch_o
);

  logic [10:0] cx_q, cx_d, cy_q, cy_d;
  logic [10:0] minor_q, minor_d, major_q, major_d;
  logic [15:0] dec_q, dec_d;
  logic [15:0] color_q, color_d;
  logic        active_q, active_d;

  logic        start;
  logic [10:0] xn, yn;
  logic [11:0] diff;
  logic [15:0] inc_a, inc_b;
  logic [10:0] cen_x, cen_y, u, v;
  logic [11:0] ex, ey, eu, ev;
  logic [11:0] xpu, xmu, xpv, xmv, ypu, ymu, ypv, ymv;
  logic [ccpg_pkg::NUM_PTS-1:0][11:0] ptx, pty;
  logic [ccpg_pkg::NUM_PTS-1:0] vis;

  always_comb begin
    start = (cmd_i == ccpg_pkg::CMD_START);
    xn    = minor_q + 11'd1;
    yn    = dec_q[15] ? major_q : major_q - 11'd1;
    diff  = {1'b0, minor_q} - {1'b0, major_q};
    inc_a = {3'b000, minor_q, 2'b00} + 16'd6;
    inc_b = {{2{diff[11]}}, diff, 2'b00} + 16'd10;

    cx_d     = cx_q;
    cy_d     = cy_q;
    minor_d  = minor_q;
    major_d  = major_q;
    dec_d    = dec_q;
    color_d  = color_q;
    active_d = active_q;
    if (start) begin
      cx_d     = center_x_i;
      cy_d     = center_y_i;
      minor_d  = '0;
      major_d  = {1'b0, radius_i};
      dec_d    = 16'd3 - {5'b00000, radius_i, 1'b0};
      color_d  = pen_color_i;
      active_d = (radius_i > 10'd1);
    end else if (active_q) begin
      minor_d  = xn;
      major_d  = yn;
      dec_d    = dec_q + (dec_q[15] ? inc_a : inc_b);
      active_d = (xn < yn);
    end
  end

  always_comb begin
    cen_x = start ? center_x_i : cx_q;
    cen_y = start ? center_y_i : cy_q;
    u     = start ? 11'd0 : xn;
    v     = start ? {1'b0, radius_i} : yn;
    ex    = {cen_x[10], cen_x};
    ey    = {cen_y[10], cen_y};
    eu    = {1'b0, u};
    ev    = {1'b0, v};
    xpu = ex + eu;
    xmu = ex - eu;
    xpv = ex + ev;
    xmv = ex - ev;
    ypu = ey + eu;
    ymu = ey - eu;
    ypv = ey + ev;
    ymv = ey - ev;
    ptx[0] = xpu; pty[0] = ypv;
    ptx[1] = xmu; pty[1] = ypv;
    ptx[2] = xpu; pty[2] = ymv;
    ptx[3] = xmu; pty[3] = ymv;
    ptx[4] = xpv; pty[4] = ypu;
    ptx[5] = xmv; pty[5] = ypu;
    ptx[6] = xpv; pty[6] = ymu;
    ptx[7] = xmv; pty[7] = ymu;
    for (int k = 0; k < ccpg_pkg::NUM_PTS; k++) begin
      vis[k]         = ccpg_pkg::on_screen(ptx[k], pty[k]);
      batch_o.px[k]  = ptx[k][9:0];
      batch_o.py[k]  = pty[k][9:0];
    end
    if (start) begin
      batch_o.mask = (radius_i != 10'd0) ? (vis & ccpg_pkg::START_SLOTS) : '0;
    end else begin
      batch_o.mask = active_q ? vis : '0;
    end
    batch_o.color    = start ? pen_color_i : color_q;
    batch_o.finished = !active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      minor_q  <= '0;
      major_q  <= '0;
      dec_q    <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      minor_q  <= minor_d;
      major_q  <= major_d;
      dec_q    <= dec_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

endmodule

### hdl/ccpg_emit.sv
module ccpg_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ccpg_pkg::batch_t batch_i,
  output logic             ready_o,
  output logic             busy_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [9:0]       pixel_x_o,
  output logic [9:0]       pixel_y_o,
  output logic [15:0]      pixel_color_o,
  output logic             plot_o,
  output logic             last_o,
  output logic             finished_o
);

  ccpg_pkg::batch_t             batch_q;
  logic [ccpg_pkg::NUM_PTS-1:0] mask_q, sel, rest;
  logic                         marker_q;
  logic                         pop, last;
  logic [9:0]                   sx, sy;

  logic        out_valid_q;
  logic [9:0]  out_x_q, out_y_q;
  logic [15:0] out_color_q;
  logic        out_plot_q, out_last_q, out_fin_q;

  always_comb begin
    busy_o = (|mask_q) | marker_q;
    sel    = mask_q & (~mask_q + 8'd1);
    rest   = mask_q & ~sel;
    last   = (rest == '0);
    pop    = busy_o && (!out_valid_q || ready_i);
    sx     = '0;
    sy     = '0;
    for (int k = 0; k < ccpg_pkg::NUM_PTS; k++) begin
      sx = sx | (sel[k] ? batch_q.px[k] : 10'd0);
      sy = sy | (sel[k] ? batch_q.py[k] : 10'd0);
    end
    ready_o = !busy_o || (pop && last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      marker_q <= 1'b0;
    end else if (load_i) begin
      mask_q   <= batch_i.mask;
      marker_q <= (batch_i.mask == '0);
    end else if (pop) begin
      mask_q   <= rest;
      marker_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      batch_q <= batch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_x_q     <= sx;
      out_y_q     <= sy;
      out_color_q <= marker_q ? 16'd0 : batch_q.color;
      out_plot_q  <= !marker_q;
      out_last_q  <= last;
      out_fin_q   <= batch_q.finished;
    end
  end

  assign valid_o       = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign plot_o        = out_plot_q;
  assign last_o        = out_last_q;
  assign finished_o    = out_fin_q;

endmodule

### hdl/clipped_circle_point_generator_top.sv
// Each accepted word is held in the point buffer, and its results leave through the output register.
// A word holds the point buffer until all of its results, one to eight, have drained through
// the single output register at one pixel per cycle, stalled while m_axis_tready is low.
// The next word can be accepted while the last result of a word enters the output register.
// Reset (rst_ni low, asynchronous) clears the circle state and drops any pending output.
module clipped_circle_point_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // center_x[10:0], center_y[21:11], radius[31:22], pen_color[47:32]
  input  logic [0:0]  s_axis_tuser,  // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // pixel_x[9:0], pixel_y[19:10], pixel_color[35:20], finished[36], zero[39:37]
  output logic [0:0]  m_axis_tuser,  // plot[0]
  output logic        m_axis_tlast   // last_of_run
);

  ccpg_pkg::batch_t batch;
  logic             in_acc, emit_ready, emit_busy;
  logic [9:0]       pixel_x, pixel_y;
  logic [15:0]      pixel_color;
  logic             plot, finished;

  assign in_acc        = s_axis_tvalid && emit_ready;
  assign s_axis_tready = emit_ready;

  ccpg_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .cmd_i       (ccpg_pkg::cmd_e'(s_axis_tuser[0])),
    .center_x_i  (s_axis_tdata[10:0]),
    .center_y_i  (s_axis_tdata[21:11]),
    .radius_i    (s_axis_tdata[31:22]),
    .pen_color_i (s_axis_tdata[47:32]),
    .batch_o     (batch)
  );

  ccpg_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_acc),
    .batch_i       (batch),
    .ready_o       (emit_ready),
    .busy_o        (emit_busy),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .plot_o        (plot),
    .last_o        (m_axis_tlast),
    .finished_o    (finished)
  );

  assign m_axis_tdata = {3'b000, finished, pixel_color, pixel_y, pixel_x};
  assign m_axis_tuser = plot;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> emit_busy)
    else $error("accepted word left no pending result");

  a_marker_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !plot) |-> (m_axis_tlast && pixel_x == 10'd0 && pixel_y == 10'd0
                                  && pixel_color == 16'd0))
    else $error("marker word malformed");

  a_on_screen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && plot) |-> (32'(pixel_x) < ccpg_pkg::SCREEN_W
                                 && 32'(pixel_y) < ccpg_pkg::SCREEN_H))
    else $error("plotted pixel off screen");

endmodule
